// File: rtl/core/krr_pkg.sv
package krr_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned MaxEmits   = MaxResults - 1;
  localparam int unsigned RunLenW    = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ACT_EMIT    = 2'd0,
    ACT_CTRL    = 2'd1,
    ACT_PASS    = 2'd2,
    ACT_SWALLOW = 2'd3
  } krr_action_e;

  // virtual key codes
  localparam logic [7:0] KEY_BACK     = 8'h08;
  localparam logic [7:0] KEY_RETURN   = 8'h0D;
  localparam logic [7:0] KEY_CONTROL  = 8'h11;
  localparam logic [7:0] KEY_LCONTROL = 8'hA2;
  localparam logic [7:0] KEY_RCONTROL = 8'hA3;
  localparam logic [7:0] KEY_OEM1     = 8'hBA;
  localparam logic [7:0] KEY_PLUS     = 8'hBB;
  localparam logic [7:0] KEY_COMMA    = 8'hBC;
  localparam logic [7:0] KEY_MINUS    = 8'hBD;
  localparam logic [7:0] KEY_PERIOD   = 8'hBE;
  localparam logic [7:0] KEY_OEM2     = 8'hBF;
  localparam logic [7:0] KEY_OEM4     = 8'hDB;
  localparam logic [7:0] KEY_OEM6     = 8'hDD;
  localparam logic [7:0] KEY_OEM7     = 8'hDE;
  localparam logic [7:0] KEY_1        = 8'h31;
  localparam logic [7:0] KEY_2        = 8'h32;
  localparam logic [7:0] KEY_3        = 8'h33;
  localparam logic [7:0] KEY_4        = 8'h34;
  localparam logic [7:0] KEY_5        = 8'h35;
  localparam logic [7:0] KEY_A        = 8'h41;
  localparam logic [7:0] KEY_B        = 8'h42;
  localparam logic [7:0] KEY_C        = 8'h43;
  localparam logic [7:0] KEY_D        = 8'h44;
  localparam logic [7:0] KEY_E        = 8'h45;
  localparam logic [7:0] KEY_F        = 8'h46;
  localparam logic [7:0] KEY_G        = 8'h47;
  localparam logic [7:0] KEY_H        = 8'h48;
  localparam logic [7:0] KEY_I        = 8'h49;
  localparam logic [7:0] KEY_J        = 8'h4A;
  localparam logic [7:0] KEY_K        = 8'h4B;
  localparam logic [7:0] KEY_L        = 8'h4C;
  localparam logic [7:0] KEY_M        = 8'h4D;
  localparam logic [7:0] KEY_N        = 8'h4E;
  localparam logic [7:0] KEY_O        = 8'h4F;
  localparam logic [7:0] KEY_P        = 8'h50;
  localparam logic [7:0] KEY_Q        = 8'h51;
  localparam logic [7:0] KEY_R        = 8'h52;
  localparam logic [7:0] KEY_S        = 8'h53;
  localparam logic [7:0] KEY_T        = 8'h54;
  localparam logic [7:0] KEY_U        = 8'h55;
  localparam logic [7:0] KEY_V        = 8'h56;
  localparam logic [7:0] KEY_W        = 8'h57;
  localparam logic [7:0] KEY_X        = 8'h58;
  localparam logic [7:0] KEY_Y        = 8'h59;
  localparam logic [7:0] KEY_Z        = 8'h5A;

  typedef struct packed {
    logic [7:0] key_code;
    logic       key_release;
    logic       injected;
    logic       shift_held;
    logic       alt_held;
    logic       ime_on;
  } krr_item_t;

  typedef struct packed {
    krr_action_e action;
    logic [7:0]  emitted_key;
    logic        last_of_run;
  } krr_res_t;

  typedef krr_res_t [MaxResults-1:0] krr_run_t;

  typedef struct packed {
    logic             hit;
    logic [3:0][7:0]  seq;     // layer sequence, element 0 first
    logic [2:0]       len;
    logic [7:0]       plain;
    logic             clears;
  } krr_expand_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] to;
  } krr_map_t;

  function automatic krr_expand_t expand_lookup(input logic [7:0] k);
    krr_expand_t e;
    e = '0;
    e.hit = 1'b1;
    case (k)
      KEY_1: e = '{1'b1, {KEY_N, KEY_N, KEY_A, KEY_Y}, 3'd4, KEY_1, 1'b1};
      KEY_2: e = '{1'b1, {KEY_N, KEY_N, KEY_O, KEY_Y}, 3'd4, KEY_2, 1'b1};
      KEY_3: e = '{1'b1, {KEY_N, KEY_N, KEY_E, KEY_Y}, 3'd4, KEY_3, 1'b1};
      KEY_4: e = '{1'b1, {KEY_N, KEY_N, KEY_U, KEY_Y}, 3'd4, KEY_4, 1'b1};
      KEY_5: e = '{1'b1, {KEY_N, KEY_N, KEY_I, KEY_H}, 3'd4, KEY_5, 1'b1};
      KEY_Q: e = '{1'b1, {8'h00, 8'h00, KEY_A, KEY_Y}, 3'd2, KEY_OEM7, 1'b1};
      KEY_W: e = '{1'b1, {8'h00, 8'h00, KEY_O, KEY_Y}, 3'd2, KEY_COMMA, 1'b1};
      KEY_E: e = '{1'b1, {8'h00, 8'h00, KEY_E, KEY_Y}, 3'd2, KEY_PERIOD, 1'b1};
      KEY_R: e = '{1'b1, {8'h00, 8'h00, KEY_U, KEY_Y}, 3'd2, KEY_MINUS, 1'b1};
      KEY_T: e = '{1'b1, {8'h00, 8'h00, KEY_I, KEY_H}, 3'd2, KEY_PLUS, 1'b1};
      KEY_Z: e = '{1'b1, {8'h00, KEY_N, KEY_N, KEY_A}, 3'd3, KEY_OEM1, 1'b0};
      KEY_X: e = '{1'b1, {8'h00, KEY_N, KEY_N, KEY_O}, 3'd3, KEY_X, 1'b0};
      KEY_C: e = '{1'b1, {8'h00, KEY_N, KEY_N, KEY_E}, 3'd3, KEY_C, 1'b0};
      KEY_V: e = '{1'b1, {8'h00, KEY_N, KEY_N, KEY_U}, 3'd3, KEY_L, 1'b0};
      KEY_B: e = '{1'b1, {8'h00, KEY_N, KEY_N, KEY_I}, 3'd3, KEY_OEM2, 1'b0};
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic krr_map_t map_lookup(input logic [7:0] k);
    krr_map_t m;
    m.hit = 1'b1;
    m.to  = 8'h00;
    case (k)
      KEY_MINUS:  m.to = KEY_OEM4;
      KEY_PLUS:   m.to = KEY_OEM6;
      KEY_Y:      m.to = KEY_Y;
      KEY_U:      m.to = KEY_D;
      KEY_I:      m.to = KEY_G;
      KEY_O:      m.to = KEY_F;
      KEY_P:      m.to = KEY_P;
      KEY_OEM4:   m.to = KEY_B;
      KEY_OEM6:   m.to = KEY_V;
      KEY_A:      m.to = KEY_A;
      KEY_S:      m.to = KEY_O;
      KEY_D:      m.to = KEY_E;
      KEY_F:      m.to = KEY_U;
      KEY_G:      m.to = KEY_I;
      KEY_H:      m.to = KEY_H;
      KEY_J:      m.to = KEY_T;
      KEY_K:      m.to = KEY_K;
      KEY_L:      m.to = KEY_R;
      KEY_OEM1:   m.to = KEY_S;
      KEY_OEM7:   m.to = KEY_Q;
      KEY_N:      m.to = KEY_N;
      KEY_M:      m.to = KEY_M;
      KEY_COMMA:  m.to = KEY_W;
      KEY_PERIOD: m.to = KEY_J;
      KEY_OEM2:   m.to = KEY_Z;
      default:    m.hit = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic is_consonant(input logic [7:0] k);
    logic c;
    case (k) inside
      KEY_B, KEY_C, KEY_D, KEY_F, KEY_G, KEY_H, KEY_J, KEY_K, KEY_L, KEY_M, KEY_N,
      KEY_P, KEY_Q, KEY_R, KEY_S, KEY_T, KEY_V, KEY_W, KEY_X, KEY_Y, KEY_Z: c = 1'b1;
      default: c = 1'b0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/krr_in_if.sv
interface krr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       key_release;
  logic       injected;
  logic       shift_held;
  logic       alt_held;
  logic       ime_on;

  modport source (
    output valid, key_code, key_release, injected, shift_held, alt_held, ime_on,
    input  ready
  );
  modport sink (
    input  valid, key_code, key_release, injected, shift_held, alt_held, ime_on,
    output ready
  );
endinterface

// File: rtl/core/krr_out_if.sv
interface krr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] emitted_key;
  logic       last_of_run;

  modport source (
    output valid, action, emitted_key, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, action, emitted_key, last_of_run,
    output ready
  );
endinterface

// File: rtl/core/krr_engine.sv
module krr_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  krr_pkg::krr_item_t item_i,
  input  logic               advance_i,
  output krr_pkg::krr_run_t  run_o,
  output logic [krr_pkg::RunLenW-1:0] run_len_o
);
  import krr_pkg::*;

  logic       ctrl_down_q, ctrl_down_d;
  logic       remap_en_q, remap_en_d;
  logic       ext_en_q, ext_en_d;
  logic [7:0] prev_key_q, prev_key_d;
  logic       layer_q, layer_d;

  logic [2:0]       n_emit;
  logic [3:0][7:0]  emit_key;
  krr_action_e      emit_act;
  krr_action_e      verdict;
  krr_expand_t      exp_hit;
  krr_map_t         map_hit;
  logic [7:0]       k;

  assign k       = item_i.key_code;
  assign exp_hit = expand_lookup(k);
  assign map_hit = map_lookup(k);

  always_comb begin
    ctrl_down_d = ctrl_down_q;
    remap_en_d  = remap_en_q;
    ext_en_d    = ext_en_q;
    prev_key_d  = prev_key_q;
    layer_d     = layer_q;
    n_emit      = 3'd0;
    emit_key    = '0;
    emit_act    = ACT_EMIT;
    verdict     = ACT_PASS;

    if (k == KEY_CONTROL || k == KEY_LCONTROL || k == KEY_RCONTROL) begin
      if (!item_i.injected) begin
        ctrl_down_d = !item_i.key_release;
        verdict     = ACT_SWALLOW;
      end
    end else if (item_i.key_release) begin
      verdict = ACT_PASS;
    end else if (ctrl_down_q && !item_i.injected) begin
      // ctrl chords
      n_emit  = 3'd1;
      verdict = ACT_SWALLOW;
      if (k == KEY_M) begin
        emit_key[0] = KEY_RETURN;
      end else if (k == KEY_H) begin
        emit_key[0] = KEY_BACK;
      end else begin
        emit_key[0] = k;
        emit_act    = ACT_CTRL;
      end
    end else if (item_i.alt_held && k == KEY_Q) begin
      remap_en_d = !remap_en_q;
      verdict    = ACT_SWALLOW;
    end else if (item_i.alt_held && k == KEY_X) begin
      ext_en_d = !ext_en_q;
      verdict  = ACT_SWALLOW;
    end else if (!remap_en_q || !item_i.ime_on) begin
      verdict = ACT_PASS;
    end else if (item_i.injected) begin
      verdict    = ACT_PASS;
      prev_key_d = k;
      if (!is_consonant(k)) begin
        layer_d = 1'b0;
      end else if (prev_key_q == k) begin
        layer_d = (k != KEY_N);
      end else if (prev_key_q == KEY_X && k == KEY_N) begin
        layer_d = 1'b0;
      end else if (layer_q) begin
        if (prev_key_q == KEY_Q) begin
          n_emit      = 3'd2;
          emit_key[0] = KEY_BACK;
          emit_key[1] = k;
        end else begin
          // wrap the consonant in vowels, keep the previous key
          n_emit      = 3'd3;
          emit_key[0] = KEY_A;
          emit_key[1] = k;
          emit_key[2] = KEY_A;
          verdict     = ACT_SWALLOW;
          prev_key_d  = prev_key_q;
        end
      end else if (ext_en_q && !item_i.shift_held) begin
        layer_d = 1'b1;
      end
    end else if (exp_hit.hit) begin
      verdict = ACT_SWALLOW;
      if (layer_q) begin
        n_emit   = exp_hit.len;
        emit_key = exp_hit.seq;
        if (exp_hit.clears) begin
          layer_d = 1'b0;
        end
      end else begin
        n_emit      = 3'd1;
        emit_key[0] = exp_hit.plain;
      end
    end else if (map_hit.hit) begin
      n_emit      = 3'd1;
      emit_key[0] = map_hit.to;
      verdict     = ACT_SWALLOW;
    end else begin
      prev_key_d = k;
      layer_d    = 1'b0;
      verdict    = ACT_PASS;
    end
  end

  // lay the run out: emissions first, verdict last
  always_comb begin
    run_o = '0;
    for (int i = 0; i < MaxResults; i++) begin
      if (i < MaxEmits && 3'(i) < n_emit) begin
        run_o[i].action      = emit_act;
        run_o[i].emitted_key = emit_key[i % MaxEmits];
        run_o[i].last_of_run = 1'b0;
      end else if (3'(i) == n_emit) begin
        run_o[i].action      = verdict;
        run_o[i].emitted_key = 8'h00;
        run_o[i].last_of_run = 1'b1;
      end
    end
  end

  assign run_len_o = RunLenW'(n_emit) + RunLenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_down_q <= 1'b0;
      remap_en_q  <= 1'b1;
      ext_en_q    <= 1'b1;
      prev_key_q  <= 8'h00;
      layer_q     <= 1'b0;
    end else if (advance_i) begin
      ctrl_down_q <= ctrl_down_d;
      remap_en_q  <= remap_en_d;
      ext_en_q    <= ext_en_d;
      prev_key_q  <= prev_key_d;
      layer_q     <= layer_d;
    end
  end

  a_ctrl_chord_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_act == ACT_CTRL) |-> (n_emit == 3'd1 && verdict == ACT_SWALLOW))
    else $error("ctrl emission outside a single-emit swallow run");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> ($stable(prev_key_q) && $stable(layer_q) && $stable(ctrl_down_q)))
    else $error("state changed without an item");

endmodule

// File: rtl/core/krr_run_buf.sv
module krr_run_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  krr_pkg::krr_run_t           run_i,
  input  logic [krr_pkg::RunLenW-1:0] run_len_i,
  output logic                        free_o,
  krr_out_if.source                   res_o
);
  import krr_pkg::*;

  krr_run_t             rb_q, rb_d;
  logic [RunLenW-1:0]   cnt_q, cnt_d;
  logic                 pop;

  assign pop    = res_o.valid && res_o.ready;
  assign free_o = (cnt_q == '0) || (cnt_q == RunLenW'(1) && pop);

  always_comb begin
    rb_d  = rb_q;
    cnt_d = cnt_q;
    if (load_i) begin
      rb_d  = run_i;
      cnt_d = run_len_i;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        rb_d[i] = rb_q[i + 1];
      end
      rb_d[MaxResults-1] = '0;
      cnt_d = cnt_q - RunLenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rb_q <= rb_d;
  end

  assign res_o.valid       = (cnt_q != '0);
  assign res_o.action      = rb_q[0].action;
  assign res_o.emitted_key = rb_q[0].emitted_key;
  assign res_o.last_of_run = rb_q[0].last_of_run;

  a_last_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (rb_q[0].last_of_run == (cnt_q == RunLenW'(1))))
    else $error("verdict flag out of step with run count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RunLenW'(MaxResults))
    else $error("run count overflow");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("run loaded over pending results");

  a_load_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q == $past(run_len_i))
    else $error("run length not captured");

endmodule

// File: rtl/core/keyboard_layout_romaji_remapper.sv
// Romaji key remapper. Each key event transfer on evt_i yields a run of one to
// five result transfers on res_o: zero to four emitted keys (action emit or ctrl
// plus key) followed by exactly one verdict (pass or swallow the original event)
// flagged by last_of_run. An event waits in the input register, is decoded
// against the remapper state in the cycle it leaves and drops its whole run
// into a five-entry run buffer, which drains one result per cycle while res_o
// is ready. The next event is taken while the run still drains, and its run
// loads as the last result of the previous one leaves, so with res_o always
// ready the results of successive events follow back to back, paced by the
// single result port.
module keyboard_layout_romaji_remapper (
  input  logic    clk_i,
  input  logic    rst_ni,
  krr_in_if.sink  evt_i,
  krr_out_if.source res_o
);
  import krr_pkg::*;

  // input register
  logic      s1_valid_q;
  krr_item_t s1_item_q;

  // run handoff between decode and run buffer
  krr_run_t           run;
  logic [RunLenW-1:0] run_len;
  logic               rb_free;
  logic               load;

  // an item moves on once the run buffer has room for its run
  assign load        = s1_valid_q && rb_free;
  assign evt_i.ready = !s1_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_valid_q <= evt_i.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      s1_item_q <= '{evt_i.key_code, evt_i.key_release, evt_i.injected,
                     evt_i.shift_held, evt_i.alt_held, evt_i.ime_on};
    end
  end

  // decode and remapper state (ctrl tracking, toggles, consonant layer)
  krr_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (s1_item_q),
    .advance_i (load),
    .run_o     (run),
    .run_len_o (run_len)
  );

  // serialize the run onto the result channel
  krr_run_buf u_run_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .run_i     (run),
    .run_len_i (run_len),
    .free_o    (rb_free),
    .res_o     (res_o)
  );

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !load) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input register dropped a waiting item");

endmodule
